// ===== design/pidaw_pkg.sv =====
`default_nettype none
package pidaw_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ERR_W         = SAMPLE_WIDTH + 1;
   localparam int INT_W         = 48;
   localparam int OUT_W         = 32;
   localparam int TICK_W        = 32;
   localparam int GAIN_W        = 32;
   localparam int LIM_W         = 2 * OUT_W;
   localparam int CTRL_W        = 3;
   localparam int ISUM_W        = 64;

   // shared multiplier: 33-bit signed A times one 16-bit slice of a 64-bit B
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = 4;
   localparam int CHUNK_IDX_W = $clog2(CHUNKS);
   localparam int MA_W        = GAIN_W + 1;
   localparam int MB_W        = CHUNK_W * CHUNKS;
   localparam int PP_W        = MA_W + CHUNK_W + 1;
   localparam int ACC_W       = MA_W + MB_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [LIM_W-1:0]         LIMITS_RST   = 64'h7FFF_FFFF_8000_0000;
   localparam logic signed [INT_W-1:0]  INT_LOW_RST  = 48'sh8000_0000_0000;
   localparam logic signed [INT_W-1:0]  INT_HIGH_RST = 48'sh7FFF_FFFF_FFFF;
   localparam logic [TICK_W-1:0]        INTERVAL_RST = 32'd200;
   localparam logic [CTRL_W-1:0]        CONTROL_RST  = 3'd5;

   localparam int CTRL_AUTO   = 0;
   localparam int CTRL_ABS    = 1;
   localparam int CTRL_CUSTOM = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP, CSR_KI, CSR_KD, CSR_LIMITS,
      CSR_INT_LOW, CSR_INT_HIGH, CSR_INTERVAL, CSR_CONTROL
   } csr_index_type;

   typedef struct packed {
      logic                           action;
      logic signed [SAMPLE_WIDTH-1:0] target;
      logic signed [SAMPLE_WIDTH-1:0] measurement;
      logic [TICK_W-1:0]              now_ticks;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    updated;
   } rsp_type;

   typedef enum logic [1:0] {MSEL_ERR_DT, MSEL_P, MSEL_I, MSEL_D} msel_type;

   typedef struct packed {
      logic                   load;
      logic                   clr_int;
      logic                   prep;
      logic                   mul;
      msel_type               msel;
      logic [CHUNK_IDX_W-1:0] chunk;
      logic                   int_upd;
      logic                   term_add;
      logic                   out_upd;
      logic                   rsp_load;
      logic                   rsp_upd;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic compute;
      logic div_done;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_PREP, ST_MUL_EDT, ST_INT, ST_MUL_P, ST_ADD_P,
      ST_MUL_I, ST_ADD_I, ST_WAIT_DIV, ST_MUL_D, ST_ADD_D, ST_OUT, ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== design/pidaw_div.sv =====
`default_nettype none
module pidaw_div #(
   parameter int DIVD_W = 34
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [DIVD_W-1:0]               dividend,
   input  wire logic [pidaw_pkg::TICK_W-1:0]    divisor,
   input  wire logic                            neg,
   output logic                                 done,
   output logic signed [DIVD_W:0]               quotient
);
   import pidaw_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] q_ff, q_in;
   logic [TICK_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic              neg_ff, neg_in, zero_ff, zero_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [TICK_W:0]   rem_sh, diff;
   logic              fits;

   assign rem_sh = {rem_ff, q_ff[DIVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign fits   = !diff[TICK_W];

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = neg;
         zero_in = (divisor == '0);
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIVD_W-2:0], fits};
         rem_in = fits ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   // truncation toward zero: divide magnitudes, then restore the sign
   assign quotient = zero_ff ? '0 : (neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff}));

endmodule
`default_nettype wire

// ===== design/pidaw_dp.sv =====
`default_nettype none
module pidaw_dp #(
   parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pidaw_pkg::cmd_type                cmd,
   output pidaw_pkg::sts_type                     sts,
   input  wire pidaw_pkg::req_type                req_data,
   output pidaw_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [pidaw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pidaw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidaw_pkg::*;

   localparam int DIFF_W = ERR_W + 1;
   localparam int DIVD_W = DIFF_W + FRAC_BITS;
   localparam int QUO_W  = DIVD_W + 1;

   // configuration
   logic signed [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [LIM_W-1:0]         lim_ff;
   logic signed [INT_W-1:0]  ilo_ff, ihi_ff;
   logic [TICK_W-1:0]        ival_ff;
   logic [CTRL_W-1:0]        ctl_ff;

   // controller state and working registers
   req_type                  item_ff;
   logic signed [ERR_W-1:0]  err_ff, prev_ff;
   logic signed [INT_W-1:0]  int_ff, int_in;
   logic signed [OUT_W-1:0]  out_ff;
   logic [TICK_W-1:0]        last_ff, dt_ff;
   logic                     skip_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, tot_ff, tot_in;
   rsp_type                  rsp_ff;

   logic signed [ERR_W-1:0]  err_c;
   logic [TICK_W-1:0]        dt_c;
   logic signed [OUT_W-1:0]  omin, omax;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag;
   logic                     chg, skip_c, div_done;
   logic signed [QUO_W-1:0]  deriv;

   logic signed [MA_W-1:0]   ma;
   logic signed [MB_W-1:0]   mb;
   logic [CHUNK_W-1:0]       seg;
   logic signed [CHUNK_W:0]  mc;
   logic signed [PP_W-1:0]   pp;
   logic signed [ACC_W-1:0]  ppx;
   logic signed [ISUM_W-1:0] isum, ihi_x, ilo_x;
   logic signed [ACC_W-1:0]  res, omin_x, omax_x;

   assign err_c = {item_ff.target[SAMPLE_WIDTH-1], item_ff.target}
                - {item_ff.measurement[SAMPLE_WIDTH-1], item_ff.measurement};
   assign dt_c  = item_ff.now_ticks - last_ff;
   assign omin  = $signed(lim_ff[OUT_W-1:0]);
   assign omax  = $signed(lim_ff[LIM_W-1:OUT_W]);

   assign sts.is_clear = item_ff.action;
   assign sts.compute  = ctl_ff[CTRL_AUTO] && (dt_c >= ival_ff);
   assign sts.div_done = div_done;

   assign diff   = {err_c[ERR_W-1], err_c} - {prev_ff[ERR_W-1], prev_ff};
   assign mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   // err * previous <= 0 without a multiply
   assign chg    = (err_c == '0) || (prev_ff == '0) || (err_c[ERR_W-1] != prev_ff[ERR_W-1]);
   assign skip_c = ((out_ff >= omax) && (err_c > 0)) || ((out_ff <= omin) && (err_c < 0));

   pidaw_div #(.DIVD_W(DIVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.prep),
      .dividend ({mag, {FRAC_BITS{1'b0}}}),
      .divisor  (dt_c),
      .neg      (diff[DIFF_W-1]),
      .done     (div_done),
      .quotient (deriv)
   );

   // shared multiplier, one 16-bit slice of B per cycle, top slice signed
   always_comb begin
      unique case (cmd.msel)
         MSEL_ERR_DT: ma = $signed({1'b0, dt_ff});
         MSEL_P:      ma = {kp_ff[GAIN_W-1], kp_ff};
         MSEL_I:      ma = {ki_ff[GAIN_W-1], ki_ff};
         MSEL_D:      ma = {kd_ff[GAIN_W-1], kd_ff};
         default:     ma = '0;
      endcase
      unique case (cmd.msel)
         MSEL_ERR_DT, MSEL_P: mb = {{(MB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         MSEL_I:              mb = {{(MB_W-INT_W){int_ff[INT_W-1]}}, int_ff};
         MSEL_D:              mb = {{(MB_W-QUO_W){deriv[QUO_W-1]}}, deriv};
         default:             mb = '0;
      endcase
   end

   assign seg = mb[cmd.chunk*CHUNK_W +: CHUNK_W];
   assign mc  = {(cmd.chunk == CHUNK_IDX_W'(CHUNKS - 1)) ? seg[CHUNK_W-1] : 1'b0, seg};
   assign pp  = ma * mc;
   assign ppx = {{(ACC_W-PP_W){pp[PP_W-1]}}, pp};

   assign isum  = $signed({{(ISUM_W-INT_W){int_ff[INT_W-1]}}, int_ff}) + $signed(acc_ff[ISUM_W-1:0]);
   assign ihi_x = {{(ISUM_W-INT_W){ihi_ff[INT_W-1]}}, ihi_ff};
   assign ilo_x = {{(ISUM_W-INT_W){ilo_ff[INT_W-1]}}, ilo_ff};

   assign omin_x = {{(ACC_W-OUT_W){omin[OUT_W-1]}}, omin};
   assign omax_x = {{(ACC_W-OUT_W){omax[OUT_W-1]}}, omax};
   assign res    = ctl_ff[CTRL_ABS] ? tot_ff
                                    : tot_ff + {{(ACC_W-OUT_W){out_ff[OUT_W-1]}}, out_ff};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.mul)
         acc_in = ((cmd.chunk == '0) ? '0 : acc_ff) + (ppx <<< (cmd.chunk * CHUNK_W));
      tot_in = tot_ff;
      if (cmd.prep)
         tot_in = '0;
      else if (cmd.term_add)
         tot_in = tot_ff + (acc_ff >>> FRAC_BITS);
      int_in = int_ff;
      if (cmd.clr_int || (cmd.prep && ctl_ff[CTRL_CUSTOM] && chg))
         int_in = '0;
      else if (cmd.int_upd && !skip_ff) begin
         if (isum > ihi_x)
            int_in = ihi_ff;
         else if (isum < ilo_x)
            int_in = ilo_ff;
         else
            int_in = isum[INT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load)
         item_ff <= req_data;
      if (cmd.prep) begin
         err_ff  <= err_c;
         dt_ff   <= dt_c;
         skip_ff <= skip_c;
      end
      acc_ff <= acc_in;
      tot_ff <= tot_in;
      if (cmd.rsp_load) begin
         rsp_ff.drive   <= out_ff;
         rsp_ff.updated <= cmd.rsp_upd;
      end
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         lim_ff  <= LIMITS_RST;
         ilo_ff  <= INT_LOW_RST;
         ihi_ff  <= INT_HIGH_RST;
         ival_ff <= INTERVAL_RST;
         ctl_ff  <= CONTROL_RST;
         int_ff  <= '0;
         prev_ff <= '0;
         out_ff  <= '0;
         last_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_KP:       kp_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
               CSR_KI:       ki_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
               CSR_KD:       kd_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
               CSR_LIMITS:   lim_ff  <= csr_wdata[LIM_W-1:0];
               CSR_INT_LOW:  ilo_ff  <= $signed(csr_wdata[INT_W-1:0]);
               CSR_INT_HIGH: ihi_ff  <= $signed(csr_wdata[INT_W-1:0]);
               CSR_INTERVAL: ival_ff <= csr_wdata[TICK_W-1:0];
               CSR_CONTROL:  ctl_ff  <= csr_wdata[CTRL_W-1:0];
               default:      ;
            endcase
         end
         int_ff <= int_in;
         if (cmd.prep)
            last_ff <= item_ff.now_ticks;
         if (cmd.out_upd) begin
            if (res < omin_x)
               out_ff <= omin;
            else if (res > omax_x)
               out_ff <= omax;
            else
               out_ff <= res[OUT_W-1:0];
            prev_ff <= err_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== design/pidaw_ctrl.sv =====
`default_nettype none
module pidaw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pidaw_pkg::cmd_type       cmd,
   input  wire pidaw_pkg::sts_type  sts
);
   import pidaw_pkg::*;

   localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(CHUNKS - 1);

   state_type              state_ff, state_in;
   logic [CHUNK_IDX_W-1:0] cnt_ff, cnt_in;
   logic                   upd_ff, upd_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.chunk    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            upd_in = 1'b0;
            if (sts.is_clear) begin
               cmd.clr_int = 1'b1;
               state_in    = ST_RESP;
            end else if (sts.compute) begin
               upd_in   = 1'b1;
               state_in = ST_PREP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_MUL_EDT;
         end
         ST_MUL_EDT, ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
            cmd.mul = 1'b1;
            unique case (state_ff)
               ST_MUL_EDT: cmd.msel = MSEL_ERR_DT;
               ST_MUL_P:   cmd.msel = MSEL_P;
               ST_MUL_I:   cmd.msel = MSEL_I;
               default:    cmd.msel = MSEL_D;
            endcase
            if (cnt_ff == LAST_CHUNK) begin
               cnt_in = '0;
               unique case (state_ff)
                  ST_MUL_EDT: state_in = ST_INT;
                  ST_MUL_P:   state_in = ST_ADD_P;
                  ST_MUL_I:   state_in = ST_ADD_I;
                  default:    state_in = ST_ADD_D;
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_INT: begin
            cmd.int_upd = 1'b1;
            state_in    = ST_MUL_P;
         end
         ST_ADD_P: begin
            cmd.term_add = 1'b1;
            state_in     = ST_MUL_I;
         end
         ST_ADD_I: begin
            cmd.term_add = 1'b1;
            state_in     = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            if (sts.div_done)
               state_in = ST_MUL_D;
         end
         ST_ADD_D: begin
            cmd.term_add = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            cmd.out_upd = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            // output register frees the input side once loaded
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_upd  = upd_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/pid_controller_antiwindup_unit.sv =====
`default_nettype none
// PID controller with anti-windup. Each item gives one result. A clear item or
// a sample that does not run a computation (manual mode, interval not reached)
// goes from the decision state straight to the response load. In a computing
// sample the bit-serial divider for the derivative term sets the length: it
// needs FRAC_BITS + SAMPLE_WIDTH + 2 iterations and runs alongside the err*dt,
// P and I passes of the shared 33x17 multiplier. The D pass, the accumulate,
// the output update and the response load follow the divider. One item is in
// work at a time. A finished result waits in the output register while the
// next item is accepted. A later result stalls only if that register is
// still full when it is ready. Configuration is to be written through
// csr_we/csr_index/csr_wdata only while the block is idle; the block itself
// does not enforce this.
module pid_controller_antiwindup_unit #(
   parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire pidaw_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pidaw_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [pidaw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pidaw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidaw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pidaw_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

// ===== design/pidaw_checker.sv =====
`default_nettype none
module pidaw_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire pidaw_pkg::rsp_type                rsp_data,
   input wire logic                              csr_we,
   input wire logic [pidaw_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [pidaw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidaw_pkg::*;

   logic signed [OUT_W-1:0] omin_ff, omax_ff;
   logic                    crossed;

   always_ff @(posedge clock) begin
      if (reset) begin
         omin_ff <= $signed(LIMITS_RST[OUT_W-1:0]);
         omax_ff <= $signed(LIMITS_RST[LIM_W-1:OUT_W]);
      end else if (csr_we && (csr_index_type'(csr_index) == CSR_LIMITS)) begin
         omin_ff <= $signed(csr_wdata[OUT_W-1:0]);
         omax_ff <= $signed(csr_wdata[LIM_W-1:OUT_W]);
      end
   end

   assign crossed = (omin_ff > omax_ff);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.updated && !crossed |->
         (rsp_data.drive >= omin_ff) && (rsp_data.drive <= omax_ff))
      else $error("computed drive outside output limits");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind pid_controller_antiwindup_unit pidaw_checker u_checker (.*);
`default_nettype wire
